@@ sv/assert_macros.svh @@
// assertion helpers for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while reset is released
`define CHK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/i2p_pkg.sv @@
package i2p_pkg;

  // characters with a meaning of their own
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_AND    = 8'h26;
  localparam logic [7:0] CH_OR     = 8'h7C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // error codes on the result channel
  typedef logic [1:0] err_t;
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_UNMATCHED = 2'd1;
  localparam err_t ERR_OVERFLOW = 2'd2;

  // request command
  localparam logic CMD_CHAR  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [2:0] prec_t;

  function automatic prec_t prec_of(input logic [7:0] c);
    prec_t p;
    p = 3'd0;
    if (c == CH_MUL || c == CH_DIV || c == CH_MOD) p = 3'd4;
    else if (c == CH_ADD || c == CH_SUB) p = 3'd3;
    else if (c == CH_LT || c == CH_GT) p = 3'd2;
    else if (c == CH_AND || c == CH_OR) p = 3'd1;
    return p;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

@@ sv/infix_to_postfix_converter_core.sv @@
// Shunting-yard infix to postfix converter.
// Input channel (in_valid/in_stall): one request per character, in_cmd low
// with the character on in_ch, or in_cmd high to flush at end of expression.
// Output channel (out_valid/out_stall): zero or more results per request;
// out_last marks the final result of a request. Whitespace and a successful
// open-parenthesis push give no result at all.
// Sequence: a request is accepted and its last result is handed over at the
// end; every stack entry examined adds a registered stack read and then a
// compare, and a push, an error result or the end marker adds a further
// step (S_PUSH or S_TAIL), while whitespace is only accepted. The stack
// memory port and the single precedence compare set this sequence. in_stall is
// high from acceptance until the last result is in the output register.
// Reset empties the stack (count cleared) and drops any held result.
// When the receiver stalls, the output register holds its result and the
// sequencer waits once it has a further result ready.
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [7:0]        in_ch,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              out_end_marker,
  output i2p_pkg::err_t     out_error_code,
  output logic              out_last
);

  import i2p_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_PUSH = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [1:0] OP_FLUSH = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_OPER  = 2'd2;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    opch_r, opch_nxt;
  prec_t         oprec_r, oprec_nxt;
  logic          tail_end_r, tail_end_nxt;
  err_t          tail_err_r, tail_err_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] count_m1;

  logic          pend_valid_r;
  logic [7:0]    pend_char_r;
  logic          pend_end_r;
  err_t          pend_err_r;

  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_end_r;
  err_t          out_err_r;
  logic          out_last_r;

  logic          obuf_free, go;
  logic          emit, fin, out_load;
  logic [7:0]    emit_char;
  logic          emit_end;
  err_t          emit_err;
  logic          rd_en, wr_en;
  logic [7:0]    top_ch;

  assign count_m1  = count_r - ONE_C;
  assign obuf_free = !out_valid_r || !out_stall;
  assign go        = !pend_valid_r || obuf_free;
  assign in_stall  = (state_r != S_IDLE);

  i2p_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (opch_r),
    .rd_en   (rd_en),
    .rd_addr (count_m1[AW-1:0]),
    .rd_data (top_ch)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    opch_nxt     = opch_r;
    oprec_nxt    = oprec_r;
    tail_end_nxt = tail_end_r;
    tail_err_nxt = tail_err_r;
    count_nxt    = count_r;
    emit         = 1'b0;
    emit_char    = 8'd0;
    emit_end     = 1'b0;
    emit_err     = ERR_NONE;
    fin          = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          opch_nxt  = in_ch;
          oprec_nxt = prec_of(in_ch);
          priority if (in_cmd == CMD_FLUSH) begin
            op_nxt = OP_FLUSH;
            if (count_r == '0) begin
              tail_end_nxt = 1'b1;
              tail_err_nxt = ERR_NONE;
              state_nxt    = S_TAIL;
            end else begin
              state_nxt = S_RD;
            end
          end else if (is_alnum(in_ch)) begin
            emit      = 1'b1;
            emit_char = in_ch;
            state_nxt = S_FIN;
          end else if (is_space(in_ch)) begin
            state_nxt = S_IDLE;
          end else if (in_ch == CH_LPAREN) begin
            state_nxt = S_PUSH;
          end else if (in_ch == CH_RPAREN) begin
            op_nxt = OP_CLOSE;
            if (count_r == '0) begin
              tail_end_nxt = 1'b0;
              tail_err_nxt = ERR_UNMATCHED;
              state_nxt    = S_TAIL;
            end else begin
              state_nxt = S_RD;
            end
          end else begin
            op_nxt    = OP_OPER;
            state_nxt = (count_r == '0) ? S_PUSH : S_RD;
          end
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (go) begin
          unique case (op_r)
            OP_FLUSH: begin
              emit      = 1'b1;
              emit_char = top_ch;
              count_nxt = count_m1;
              if (count_r == ONE_C) begin
                tail_end_nxt = 1'b1;
                tail_err_nxt = ERR_NONE;
                state_nxt    = S_TAIL;
              end else begin
                state_nxt = S_RD;
              end
            end
            OP_CLOSE: begin
              count_nxt = count_m1;
              if (top_ch == CH_LPAREN) begin
                state_nxt = S_FIN;
              end else begin
                emit      = 1'b1;
                emit_char = top_ch;
                if (count_r == ONE_C) begin
                  tail_end_nxt = 1'b0;
                  tail_err_nxt = ERR_UNMATCHED;
                  state_nxt    = S_TAIL;
                end else begin
                  state_nxt = S_RD;
                end
              end
            end
            OP_OPER: begin
              // an open parenthesis is a barrier, lower precedence stops popping
              if (top_ch == CH_LPAREN || prec_of(top_ch) < oprec_r) begin
                state_nxt = S_PUSH;
              end else begin
                emit      = 1'b1;
                emit_char = top_ch;
                count_nxt = count_m1;
                state_nxt = (count_r == ONE_C) ? S_PUSH : S_RD;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_PUSH: begin
        if (count_r >= DEPTH_C) begin
          tail_end_nxt = 1'b0;
          tail_err_nxt = ERR_OVERFLOW;
          state_nxt    = S_TAIL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + ONE_C;
          state_nxt = S_FIN;
        end
      end
      S_TAIL: begin
        if (go) begin
          emit      = 1'b1;
          emit_end  = tail_end_r;
          emit_err  = tail_err_r;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (obuf_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // a held result moves on once the next one is known, so last is exact
  assign out_load = (emit && pend_valid_r) || fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        pend_valid_r <= 1'b1;
      end else if (fin) begin
        pend_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    opch_r     <= opch_nxt;
    oprec_r    <= oprec_nxt;
    tail_end_r <= tail_end_nxt;
    tail_err_r <= tail_err_nxt;
    if (emit) begin
      pend_char_r <= emit_char;
      pend_end_r  <= emit_end;
      pend_err_r  <= emit_err;
    end
    if (out_load) begin
      out_char_r <= pend_char_r;
      out_end_r  <= pend_end_r;
      out_err_r  <= pend_err_r;
      out_last_r <= fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_end_marker = out_end_r;
  assign out_error_code = out_err_r;
  assign out_last       = out_last_r;

endmodule

@@ sv/i2p_stack.sv @@
module i2p_stack #(
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/i2p_checker.sv @@
`include "assert_macros.svh"

module i2p_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          in_cmd,
  input logic [7:0]    in_ch,
  input logic          out_valid,
  input logic          out_stall,
  input logic [7:0]    out_char,
  input logic          out_end_marker,
  input i2p_pkg::err_t out_error_code,
  input logic          out_last
);

  import i2p_pkg::*;

  logic [8:0]  in_bus;
  logic [11:0] out_bus;

  assign in_bus  = {in_cmd, in_ch};
  assign out_bus = {out_char, out_end_marker, out_error_code, out_last};

  `CHK_ASSERT(a_in_hold, clk, rst_n,
              in_valid && in_stall |=> in_valid && $stable(in_bus),
              "stalled request changed")
  `CHK_ASSERT(a_out_hold, clk, rst_n,
              out_valid && out_stall |=> out_valid && $stable(out_bus),
              "stalled result changed")
  `CHK_ASSERT(a_marker_final, clk, rst_n,
              out_valid && out_end_marker |->
                out_last && out_char == 8'd0 && out_error_code == ERR_NONE,
              "end marker not a clean final result")
  `CHK_ASSERT(a_err_final, clk, rst_n,
              out_valid && out_error_code != ERR_NONE |->
                out_last && out_char == 8'd0 && !out_end_marker,
              "error result not final or carries a character")
  `CHK_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result shown right after reset")

endmodule

bind infix_to_postfix_converter_core i2p_checker u_i2p_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_cmd         (in_cmd),
  .in_ch          (in_ch),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char       (out_char),
  .out_end_marker (out_end_marker),
  .out_error_code (out_error_code),
  .out_last       (out_last)
);
